/* design/psod_pkg.sv */
// Shared types and constants for the pulse speedometer / odometer block.
package psod_pkg;

    // Request codes carried on req_type
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_PULSE  = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_PULSE_DIST = 3'd0;
    localparam logic [2:0] CFG_TRIP_STEP  = 3'd1;
    localparam logic [2:0] CFG_SPEED_SCALE = 3'd2;
    localparam logic [2:0] CFG_STALE_LIMIT = 3'd3;
    localparam logic [2:0] CFG_MIN_SPEED  = 3'd4;
    localparam logic [2:0] CFG_ODO_START  = 3'd5;
    localparam logic [2:0] CFG_TRIP_START = 3'd6;

    // Field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int STEP_W     = 16;
    localparam int SCALE_W    = 20;
    localparam int LIMIT_W    = 16;
    localparam int SPEED_W    = 10;
    localparam int NEEDLE_W   = 7;
    localparam int OUT_DIST_W = 40;

    // Register reset values
    localparam logic [STEP_W-1:0]     PULSE_DIST_RST  = 16'd1068;
    localparam logic [STEP_W-1:0]     TRIP_STEP_RST   = 16'd1078;
    localparam logic [SCALE_W-1:0]    SPEED_SCALE_RST = 20'd3845;
    localparam logic [LIMIT_W-1:0]    STALE_LIMIT_RST = 16'd769;
    localparam logic [SPEED_W-1:0]    MIN_SPEED_RST   = 10'd5;
    localparam logic [OUT_DIST_W-1:0] ODO_START_RST   = 40'd0;
    localparam logic [OUT_DIST_W-1:0] TRIP_START_RST  = 40'd0;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 10'd1023;

    // speed / 10 as (speed * 205) >> 11, exact for speed <= 1023
    localparam int NEEDLE_PROD_W = 18;
    localparam logic [NEEDLE_PROD_W-1:0] NEEDLE_MUL = 18'd205;
    localparam int NEEDLE_SHIFT = 11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_EXEC,
        S_EMIT
    } psod_state_t;

    typedef struct packed {
        logic latch;      // capture the incoming request
        logic div_start;  // launch the speed division
        logic exec;       // apply the request to the state
        logic emit;       // load the output register
    } psod_cmd_t;

    typedef struct packed {
        logic is_update;  // latched request is an update
        logic div_done;   // quotient ready
    } psod_stat_t;

endpackage

/* design/pulse_speedometer_odometer.sv */
// Top level of the wheel-pulse speedometer with odometer and trip counters.
// Each input beat is a millisecond tick, a wheel pulse edge or an update
// request, and each one returns exactly one output beat showing speed,
// gauge needle target, odometer and trip after that beat took effect.
// Items are handled one at a time by a small sequencer: a tick, a pulse or
// an unused request code passes through dispatch, execute and emit to the
// output register, and the next beat can be accepted in the cycle after the
// load; an update also waits in the restoring divider, which produces one
// bit of the 20-bit speed_scale / period quotient per cycle. A finished
// beat waits in the output register while the next item is accepted; an
// item that finishes while the previous beat is still unread holds until
// the output register frees up. Speed reads zero when the period is zero,
// when the last pulse is older than stale_limit_ms, or when the saturated
// quotient is below min_speed_kph. Writing odo_start_mm or trip_start_mm
// loads the running total at once. Configuration is accepted every cycle
// and must only be written while the block is idle; unknown indexes are
// ignored.
module pulse_speedometer_odometer #(
    parameter int DIST_WIDTH = 40,  // odometer/trip counter width, 32..48
    parameter int TIME_WIDTH = 32   // millisecond counter width, 16..32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic                                clear_trip,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [psod_pkg::SPEED_W-1:0]        speed_kph,
    output logic [psod_pkg::NEEDLE_W-1:0]       needle_target,
    output logic [psod_pkg::OUT_DIST_W-1:0]     odo_mm,
    output logic [psod_pkg::OUT_DIST_W-1:0]     trip_mm,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psod_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psod_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import psod_pkg::*;

    psod_cmd_t  cmd;
    psod_stat_t stat;
    logic       cfg_we;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    psod_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    psod_dp #(
        .DIST_WIDTH (DIST_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .clear_trip    (clear_trip),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .speed_kph     (speed_kph),
        .needle_target (needle_target),
        .odo_mm        (odo_mm),
        .trip_mm       (trip_mm)
    );

`ifndef SYNTHESIS
    // one item in flight: an accepted beat closes the request channel
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // loading the output register always raises out_valid
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("output beat loaded but not presented");

    // the divider steps through every quotient bit: no quotient right after a launch
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !stat.div_done)
        else $error("divider finished too early");

    // speed / 10 cannot exceed 102
    a_needle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (needle_target <= 7'd102))
        else $error("needle target out of range");
`endif

endmodule

/* design/psod_div.sv */
// Restoring divider, one quotient bit per cycle.
module psod_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W+1:0] diff;
    logic             fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
        fits      = !diff[DVS_W+1];

        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            quo_next   = {quo_reg[DVD_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/psod_ctrl.sv */
// Sequencing state machine and output-valid tracking.
module psod_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  psod_pkg::psod_stat_t stat,
    output psod_pkg::psod_cmd_t  cmd
);
    import psod_pkg::*;

    psod_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                state_next = stat.is_update ? S_DIV : S_EXEC;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_DISPATCH:
            begin
                cmd.div_start = stat.is_update;
            end
            S_DIV:
            begin
                cmd = '0;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/psod_dp.sv */
// Datapath: configuration, time and distance counters, speed evaluation, output register.
module psod_dp #(
    parameter int DIST_WIDTH = 40,
    parameter int TIME_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  psod_pkg::psod_cmd_t                 cmd,
    output psod_pkg::psod_stat_t                stat,
    input  logic [1:0]                          req_type,
    input  logic                                clear_trip,
    input  logic                                cfg_we,
    input  logic [psod_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psod_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [psod_pkg::SPEED_W-1:0]        speed_kph,
    output logic [psod_pkg::NEEDLE_W-1:0]       needle_target,
    output logic [psod_pkg::OUT_DIST_W-1:0]     odo_mm,
    output logic [psod_pkg::OUT_DIST_W-1:0]     trip_mm
);
    import psod_pkg::*;

    // configuration
    logic [STEP_W-1:0]  pulse_dist_reg, pulse_dist_next;
    logic [STEP_W-1:0]  trip_step_reg, trip_step_next;
    logic [SCALE_W-1:0] speed_scale_reg, speed_scale_next;
    logic [LIMIT_W-1:0] stale_limit_reg, stale_limit_next;
    logic [SPEED_W-1:0] min_speed_reg, min_speed_next;

    // state
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [TIME_WIDTH-1:0] last_pulse_reg, last_pulse_next;
    logic [TIME_WIDTH-1:0] period_reg, period_next;
    logic [DIST_WIDTH-1:0] odo_total_reg, odo_total_next;
    logic [DIST_WIDTH-1:0] trip_total_reg, trip_total_next;
    logic [SPEED_W-1:0]    speed_held_reg, speed_held_next;

    // latched request
    logic [1:0] req_kind_reg;
    logic       req_clear_reg;

    // output beat
    logic [SPEED_W-1:0]    speed_out_reg;
    logic [NEEDLE_W-1:0]   needle_out_reg;
    logic [OUT_DIST_W-1:0] odo_out_reg;
    logic [OUT_DIST_W-1:0] trip_out_reg;

    logic [SCALE_W-1:0]       quotient;
    logic                     div_done;
    logic [SPEED_W-1:0]       speed_sat;
    logic [TIME_WIDTH-1:0]    age;
    logic                     stale;
    logic [SPEED_W-1:0]       speed_calc;
    logic [NEEDLE_PROD_W-1:0] needle_prod;
    logic [NEEDLE_W-1:0]      needle;

    psod_div #(
        .DVD_W (SCALE_W),
        .DVS_W (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (speed_scale_reg),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign stat.is_update = (req_kind_reg == REQ_UPDATE);
    assign stat.div_done  = div_done;

    // speed from the finished quotient
    always_comb
    begin
        speed_sat  = (|quotient[SCALE_W-1:SPEED_W]) ? SPEED_MAX : quotient[SPEED_W-1:0];
        age        = now_reg - last_pulse_reg;
        stale      = age > TIME_WIDTH'(stale_limit_reg);
        speed_calc = speed_sat;
        if ((period_reg == '0) || stale || (speed_sat < min_speed_reg))
            speed_calc = '0;
    end

    assign needle_prod = NEEDLE_PROD_W'(speed_held_reg) * NEEDLE_MUL;
    assign needle      = needle_prod[NEEDLE_SHIFT +: NEEDLE_W];

    always_comb
    begin
        pulse_dist_next  = pulse_dist_reg;
        trip_step_next   = trip_step_reg;
        speed_scale_next = speed_scale_reg;
        stale_limit_next = stale_limit_reg;
        min_speed_next   = min_speed_reg;
        now_next         = now_reg;
        last_pulse_next  = last_pulse_reg;
        period_next      = period_reg;
        odo_total_next   = odo_total_reg;
        trip_total_next  = trip_total_reg;
        speed_held_next  = speed_held_reg;

        if (cmd.exec)
        begin
            case (req_kind_reg)
                REQ_TICK:
                begin
                    now_next = now_reg + 1'b1;
                end
                REQ_PULSE:
                begin
                    period_next     = now_reg - last_pulse_reg;
                    last_pulse_next = now_reg;
                    odo_total_next  = odo_total_reg + DIST_WIDTH'(pulse_dist_reg);
                    trip_total_next = trip_total_reg + DIST_WIDTH'(trip_step_reg);
                end
                REQ_UPDATE:
                begin
                    speed_held_next = speed_calc;
                    if (req_clear_reg)
                        trip_total_next = '0;
                end
                default:
                begin
                    now_next = now_reg;
                end
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE_DIST:  pulse_dist_next  = cfg_data[STEP_W-1:0];
                CFG_TRIP_STEP:   trip_step_next   = cfg_data[STEP_W-1:0];
                CFG_SPEED_SCALE: speed_scale_next = cfg_data[SCALE_W-1:0];
                CFG_STALE_LIMIT: stale_limit_next = cfg_data[LIMIT_W-1:0];
                CFG_MIN_SPEED:   min_speed_next   = cfg_data[SPEED_W-1:0];
                CFG_ODO_START:   odo_total_next   = DIST_WIDTH'(cfg_data[OUT_DIST_W-1:0]);
                CFG_TRIP_START:  trip_total_next  = DIST_WIDTH'(cfg_data[OUT_DIST_W-1:0]);
                default:         pulse_dist_next  = pulse_dist_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_dist_reg  <= PULSE_DIST_RST;
            trip_step_reg   <= TRIP_STEP_RST;
            speed_scale_reg <= SPEED_SCALE_RST;
            stale_limit_reg <= STALE_LIMIT_RST;
            min_speed_reg   <= MIN_SPEED_RST;
            now_reg         <= '0;
            last_pulse_reg  <= '0;
            period_reg      <= '0;
            odo_total_reg   <= DIST_WIDTH'(ODO_START_RST);
            trip_total_reg  <= DIST_WIDTH'(TRIP_START_RST);
            speed_held_reg  <= '0;
        end
        else
        begin
            pulse_dist_reg  <= pulse_dist_next;
            trip_step_reg   <= trip_step_next;
            speed_scale_reg <= speed_scale_next;
            stale_limit_reg <= stale_limit_next;
            min_speed_reg   <= min_speed_next;
            now_reg         <= now_next;
            last_pulse_reg  <= last_pulse_next;
            period_reg      <= period_next;
            odo_total_reg   <= odo_total_next;
            trip_total_reg  <= trip_total_next;
            speed_held_reg  <= speed_held_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_kind_reg  <= req_type;
            req_clear_reg <= clear_trip;
        end
        if (cmd.emit)
        begin
            speed_out_reg  <= speed_held_reg;
            needle_out_reg <= needle;
            odo_out_reg    <= OUT_DIST_W'(odo_total_reg);
            trip_out_reg   <= OUT_DIST_W'(trip_total_reg);
        end
    end

    assign speed_kph     = speed_out_reg;
    assign needle_target = needle_out_reg;
    assign odo_mm        = odo_out_reg;
    assign trip_mm       = trip_out_reg;

endmodule

/* bench/pulse_speedometer_odometer_tb.sv */
// Self-checking bench for pulse_speedometer_odometer: directed table, then random phases.
module pulse_speedometer_odometer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psod_pkg::*;

    localparam int DIST_W = 40;
    localparam int TIME_W = 32;

    // req_type code the block leaves unused, and a register index it ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int SETTLE_CYCLES   = 40;   // longest item is an update
    localparam int REPORT_MAX      = 10;
    localparam int LIMIT_NS        = 5_000_000;

    // One result beat, field order matches the output ports
    typedef struct packed {
        logic [SPEED_W-1:0]    kph;
        logic [NEEDLE_W-1:0]   needle;
        logic [OUT_DIST_W-1:0] odo;
        logic [OUT_DIST_W-1:0] trip;
    } speedo_beat_t;

    // Directed table row: either a register write or a request beat.
    // typed rows carry a hand-worked result, the rest use the predictor.
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [1:0]            req;
        logic                  clr;
        logic                  typed;
        speedo_beat_t          want;
    } dir_row_t;

    function automatic dir_row_t item_row(input logic [1:0] req, input logic clr);
        dir_row_t row;
        row = '0;
        row.req = req;
        row.clr = clr;
        return row;
    endfunction

    function automatic dir_row_t checked_row(input logic [1:0] req, input logic clr,
                                             input logic [SPEED_W-1:0] kph,
                                             input logic [NEEDLE_W-1:0] needle,
                                             input logic [OUT_DIST_W-1:0] odo,
                                             input logic [OUT_DIST_W-1:0] trip);
        dir_row_t row;
        row = item_row(req, clr);
        row.typed = 1'b1;
        row.want.kph = kph;
        row.want.needle = needle;
        row.want.odo = odo;
        row.want.trip = trip;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    localparam int DIR_ROWS = 31;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // straight after reset: everything zero, zero period gives zero speed,
        // unused code changes nothing even with clear_trip set
        checked_row(REQ_TICK,   1'b0, 10'd0, 7'd0, 40'd0, 40'd0),
        checked_row(REQ_UPDATE, 1'b0, 10'd0, 7'd0, 40'd0, 40'd0),
        checked_row(REQ_UNUSED, 1'b1, 10'd0, 7'd0, 40'd0, 40'd0),
        // first pulse adds the reset distances; 3845 / 1 ms saturates
        checked_row(REQ_PULSE,  1'b0, 10'd0, 7'd0, 40'd1068, 40'd1078),
        checked_row(REQ_UPDATE, 1'b0, 10'd1023, 7'd102, 40'd1068, 40'd1078),
        reg_row(CFG_SPEED_SCALE, 40'd47),
        item_row(REQ_UPDATE, 1'b0),
        // below the minimum speed
        reg_row(CFG_MIN_SPEED, 40'd48),
        item_row(REQ_UPDATE, 1'b0),
        reg_row(CFG_MIN_SPEED, 40'd0),
        // stale pulse: one tick of age beats a zero limit
        reg_row(CFG_STALE_LIMIT, 40'd0),
        item_row(REQ_TICK, 1'b0),
        item_row(REQ_UPDATE, 1'b0),
        reg_row(CFG_STALE_LIMIT, 40'hFFFF),
        // clear_trip is ignored on tick and pulse, honored on update
        item_row(REQ_TICK, 1'b1),
        item_row(REQ_PULSE, 1'b1),
        item_row(REQ_UPDATE, 1'b1),
        // start-value writes load the totals at once
        reg_row(CFG_ODO_START, 40'hFF_FFFF_FFFF),
        reg_row(CFG_TRIP_START, 40'hFF_FFFF_FFFF),
        checked_row(REQ_UNUSED, 1'b0, 10'd23, 7'd2, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF),
        // both totals wrap; two pulses on the same ms leave a zero period
        item_row(REQ_PULSE, 1'b0),
        item_row(REQ_UPDATE, 1'b0),
        // oversized data is cut to register width; index 7 goes nowhere
        reg_row(CFG_PULSE_DIST, 40'hFF_FFFF_FFFF),
        reg_row(CFG_TRIP_STEP, 40'hAB_CDEF_0000),
        reg_row(CFG_NONE, 40'hFF_FFFF_FFFF),
        item_row(REQ_TICK, 1'b0),
        item_row(REQ_PULSE, 1'b0),
        reg_row(CFG_SPEED_SCALE, 40'h0F_FFFF),
        item_row(REQ_UPDATE, 1'b0),
        // zero scale reads zero speed
        reg_row(CFG_SPEED_SCALE, 40'd0),
        item_row(REQ_UPDATE, 1'b0)
    };

    // DUT ports; every input starts at a known value
    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            req_type = REQ_TICK;
    logic                  clear_trip = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SPEED_W-1:0]    speed_kph;
    logic [NEEDLE_W-1:0]   needle_target;
    logic [OUT_DIST_W-1:0] odo_mm;
    logic [OUT_DIST_W-1:0] trip_mm;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PULSE_DIST;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pulse_speedometer_odometer #(
        .DIST_WIDTH(DIST_W),
        .TIME_WIDTH(TIME_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .clear_trip   (clear_trip),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed_kph    (speed_kph),
        .needle_target(needle_target),
        .odo_mm       (odo_mm),
        .trip_mm      (trip_mm),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gauge predictor: register copy and running state, reset values from the package
    logic [STEP_W-1:0]  dist_per_pulse = PULSE_DIST_RST;
    logic [STEP_W-1:0]  trip_per_pulse = TRIP_STEP_RST;
    logic [SCALE_W-1:0] scale_num      = SPEED_SCALE_RST;
    logic [LIMIT_W-1:0] stale_ms       = STALE_LIMIT_RST;
    logic [SPEED_W-1:0] floor_kph      = MIN_SPEED_RST;
    logic [TIME_W-1:0]  clock_ms       = '0;
    logic [TIME_W-1:0]  last_edge_ms   = '0;
    logic [TIME_W-1:0]  period_ms      = '0;
    logic [DIST_W-1:0]  odo_acc        = DIST_W'(ODO_START_RST);
    logic [DIST_W-1:0]  trip_acc       = DIST_W'(TRIP_START_RST);
    logic [SPEED_W-1:0] held_kph       = '0;

    speedo_beat_t beats_due[$];   // predicted beats, oldest first
    speedo_beat_t got_beat;
    speedo_beat_t want_beat;

    int  fails = 0;
    int  beats_checked = 0;
    int  items_sent = 0;
    int  updates_sent = 0;
    int  regs_written = 0;
    int  rx_hold = 0;
    bit  quiet = 1'b0;   // phase with no idling on either side

    // Apply one request beat to the predicted state, return the beat it causes
    function automatic speedo_beat_t advance_gauge(input logic [1:0] req, input logic clr);
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] quot;
        speedo_beat_t      beat;
        case (req)
            REQ_TICK:
                clock_ms = clock_ms + 1'b1;
            REQ_PULSE:
            begin
                period_ms = clock_ms - last_edge_ms;
                last_edge_ms = clock_ms;
                odo_acc = odo_acc + DIST_W'(dist_per_pulse);
                trip_acc = trip_acc + DIST_W'(trip_per_pulse);
            end
            REQ_UPDATE:
            begin
                age = clock_ms - last_edge_ms;
                if (period_ms == '0)
                    held_kph = '0;
                else
                begin
                    quot = TIME_W'(scale_num) / period_ms;
                    if (quot > TIME_W'(SPEED_MAX))
                        quot = TIME_W'(SPEED_MAX);
                    if (age > TIME_W'(stale_ms) || quot < TIME_W'(floor_kph))
                        held_kph = '0;
                    else
                        held_kph = quot[SPEED_W-1:0];
                end
                if (clr)
                    trip_acc = '0;
            end
            default: ;
        endcase
        beat.kph = held_kph;
        beat.needle = NEEDLE_W'(held_kph / 10);
        beat.odo = OUT_DIST_W'(odo_acc);
        beat.trip = OUT_DIST_W'(trip_acc);
        return beat;
    endfunction

    function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PULSE_DIST:  dist_per_pulse = data[STEP_W-1:0];
            CFG_TRIP_STEP:   trip_per_pulse = data[STEP_W-1:0];
            CFG_SPEED_SCALE: scale_num = data[SCALE_W-1:0];
            CFG_STALE_LIMIT: stale_ms = data[LIMIT_W-1:0];
            CFG_MIN_SPEED:   floor_kph = data[SPEED_W-1:0];
            CFG_ODO_START:   odo_acc = DIST_W'(data[OUT_DIST_W-1:0]);
            CFG_TRIP_START:  trip_acc = DIST_W'(data[OUT_DIST_W-1:0]);
            default: ;
        endcase
    endfunction

    // Present one request beat and hold it until accepted. Called and returns at a
    // falling edge with in_valid still high; the caller lowers it when done.
    task automatic send_item(input logic [1:0] req, input logic clr,
                             input logic typed, input speedo_beat_t want);
        int           gap;
        speedo_beat_t pred;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        clear_trip <= clr;
        do @(posedge clk); while (!in_ready);
        pred = advance_gauge(req, clr);
        beats_due.push_back(typed ? want : pred);
        items_sent++;
        if (req == REQ_UPDATE)
            updates_sent++;
        @(negedge clk);
    endtask

    // Same pattern on the register write channel
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        load_reg(idx, data);
        regs_written++;
        @(negedge clk);
    endtask

    // Stop sending, wait for every predicted beat, then let the block go quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result checker: each accepted beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_beat = {speed_kph, needle_target, odo_mm, trip_mm};
            if (beats_due.size() == 0)
            begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("unexpected beat: kph=%0d needle=%0d odo=%h trip=%h",
                             got_beat.kph, got_beat.needle, got_beat.odo, got_beat.trip);
            end
            else
            begin
                want_beat = beats_due.pop_front();
                if (got_beat !== want_beat)
                begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("beat %0d: exp kph=%0d needle=%0d odo=%h trip=%h",
                                 beats_checked, want_beat.kph, want_beat.needle,
                                 want_beat.odo, want_beat.trip,
                                 " / got kph=%0d needle=%0d odo=%h trip=%h",
                                 got_beat.kph, got_beat.needle, got_beat.odo,
                                 got_beat.trip);
                end
            end
            beats_checked++;
            // stall before the next beat
            rx_hold = quiet ? 0 : $urandom_range(0, 5);
        end
    end

    // Receiver ready: low for the drawn number of cycles, then high until a beat lands
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("pulse_speedometer_odometer: mismatch");
        $finish;
    end

    initial
    begin
        int                    i;
        int                    k;
        int                    r;
        int                    p;
        int                    phase_start;
        logic                  prev_reg;
        logic [CFG_DATA_W-1:0] v_dist;
        logic [CFG_DATA_W-1:0] v_step;
        logic [CFG_DATA_W-1:0] v_scale;
        logic [CFG_DATA_W-1:0] v_stale;
        logic [CFG_DATA_W-1:0] v_min;
        logic [CFG_DATA_W-1:0] v_odo;
        logic [CFG_DATA_W-1:0] v_trip;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; register rows wait until the block is idle
        prev_reg = 1'b1;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].is_reg)
            begin
                if (!prev_reg)
                    drain();
                cfg_write(DIRECTED[i].idx, DIRECTED[i].data);
            end
            else
            begin
                if (prev_reg)
                    cfg_valid <= 1'b0;
                send_item(DIRECTED[i].req, DIRECTED[i].clr, DIRECTED[i].typed,
                          DIRECTED[i].want);
            end
            prev_reg = DIRECTED[i].is_reg;
        end

        // random phases, each with a fresh register setting
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p == 0)
            begin
                // back to reset values, random start totals
                v_dist = CFG_DATA_W'(PULSE_DIST_RST);
                v_step = CFG_DATA_W'(TRIP_STEP_RST);
                v_scale = CFG_DATA_W'(SPEED_SCALE_RST);
                v_stale = CFG_DATA_W'(STALE_LIMIT_RST);
                v_min = CFG_DATA_W'(MIN_SPEED_RST);
                v_odo = CFG_DATA_W'({$urandom, $urandom});
                v_trip = CFG_DATA_W'({$urandom, $urandom});
            end
            else if (p == 1)
            begin
                // low extremes
                v_dist = 40'd1;
                v_step = 40'd1;
                v_scale = 40'd1;
                v_stale = 40'd1;
                v_min = 40'd0;
                v_odo = 40'd0;
                v_trip = 40'd0;
            end
            else if (p == NUM_PHASES - 1)
            begin
                // high extremes; totals start close enough to wrap in the phase
                v_dist = 40'hFFFF;
                v_step = 40'hFFFF;
                v_scale = 40'hF_FFFF;
                v_stale = 40'hFFFF;
                v_min = 40'd1023;
                v_odo = 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 1000000));
                v_trip = 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 1000000));
            end
            else
            begin
                // mostly scales that land speeds across the gauge, short stale limits
                v_dist = 40'($urandom_range(1, 65535));
                v_step = 40'($urandom_range(1, 65535));
                if ($urandom_range(0, 3) == 0)
                    v_scale = 40'($urandom_range(1, 20'hF_FFFF));
                else
                    v_scale = 40'($urandom_range(1, 20000));
                v_stale = 40'($urandom_range(1, 48));
                v_min = 40'($urandom_range(0, 150));
                v_odo = CFG_DATA_W'({$urandom, $urandom});
                v_trip = CFG_DATA_W'({$urandom, $urandom});
                // now and then hand a register data wider than it holds
                if ($urandom_range(0, 5) == 0)
                    v_step = CFG_DATA_W'({$urandom, $urandom});
                if ($urandom_range(0, 5) == 0)
                    v_min = CFG_DATA_W'({$urandom, $urandom});
            end
            cfg_write(CFG_PULSE_DIST, v_dist);
            cfg_write(CFG_TRIP_STEP, v_step);
            cfg_write(CFG_SPEED_SCALE, v_scale);
            cfg_write(CFG_STALE_LIMIT, v_stale);
            cfg_write(CFG_MIN_SPEED, v_min);
            cfg_write(CFG_ODO_START, v_odo);
            cfg_write(CFG_TRIP_START, v_trip);
            cfg_write(CFG_NONE, CFG_DATA_W'({$urandom, $urandom}));
            cfg_valid <= 1'b0;

            quiet = ($urandom_range(0, 3) == 0);
            phase_start = items_sent;
            while (items_sent < phase_start + ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    // noise: any code, any clear flag
                    send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else
                begin
                    // wheel revolution: ticks, a pulse, usually an update.
                    // Longer runs of ticks push the pulse past the stale limit.
                    if (r < 25)
                        k = $urandom_range(0, (stale_ms < 60) ? int'(stale_ms) + 3 : 63);
                    else
                        k = $urandom_range(0, 10);
                    repeat (k)
                        send_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
                    send_item(REQ_PULSE, 1'($urandom_range(0, 1)), 1'b0, '0);
                    if ($urandom_range(0, 2) != 0)
                        send_item(REQ_UPDATE, ($urandom_range(0, 9) == 0), 1'b0, '0);
                end
            end
        end
        quiet = 1'b0;
        drain();

        fails += beats_due.size();
        $display("ran %0d request beats (%0d speed updates) and %0d register writes",
                 items_sent, updates_sent, regs_written);
        $display("over %0d register settings plus the directed table; %0d result beats checked",
                 NUM_PHASES, beats_checked);
        if (fails == 0)
            $display("pulse_speedometer_odometer: match");
        else
            $display("pulse_speedometer_odometer: mismatch");
        $finish;
    end

endmodule
